### sv/gravity_verlet_body_step_macros.svh
// assertion helpers used by the checker file
`ifndef GRAVITY_VERLET_BODY_STEP_MACROS_SVH
`define GRAVITY_VERLET_BODY_STEP_MACROS_SVH

// same-cycle implication
`define GVB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gvb check failed");

// next-cycle implication
`define GVB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gvb check failed");

`endif

### sv/gvb_pkg.sv
`default_nettype none

package gvb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    // width of the shared add/subtract unit and its working registers
    localparam int WIDE_W = 128;

    localparam int IN_W  = 96;
    localparam int OUT_W = 128;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFTENING  = 3'd6;

    // cap on dt^2*a before the position update
    localparam logic [WIDE_W-1:0] DT2A_CAP = WIDE_W'(1) << 40;

    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] start_vx;
        logic [31:0] start_vy;
        logic [31:0] time_step;
        logic [31:0] grav_const;
        logic [31:0] softening;
    } cfg_t;

    typedef struct packed {
        logic [31:0] other_x;
        logic [31:0] other_y;
        logic [31:0] other_mass;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic [31:0] accel_x;
        logic [31:0] accel_y;
    } res_t;

    typedef struct packed {
        logic valid;
        logic axis_y;
    } reload_t;

endpackage

`default_nettype wire

### sv/gvb_addsub.sv
`default_nettype none

// shared wide adder / subtractor; carry high on subtract means a >= b
module gvb_addsub (
    input  wire logic [gvb_pkg::WIDE_W-1:0] a,
    input  wire logic [gvb_pkg::WIDE_W-1:0] b,
    input  wire logic                       sub,
    output logic      [gvb_pkg::WIDE_W-1:0] res,
    output logic                            carry
);

    logic [gvb_pkg::WIDE_W:0] full;

    always_comb
    begin
        full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{gvb_pkg::WIDE_W{1'b0}}, sub};
        res   = full[gvb_pkg::WIDE_W-1:0];
        carry = full[gvb_pkg::WIDE_W];
    end

endmodule

`default_nettype wire

### sv/gvb_core.sv
`default_nettype none

module gvb_core #(
    parameter int FRAC_BITS = gvb_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = gvb_pkg::ACC_WIDTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire gvb_pkg::cfg_t   cfg,
    input  wire gvb_pkg::reload_t reload,
    input  wire logic            start,
    input  wire gvb_pkg::item_t  item,
    output logic                 idle,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output gvb_pkg::res_t        res
);

    localparam int W     = gvb_pkg::WIDE_W;
    localparam int NUM_W = 96 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int S_W   = 34;
    localparam int DEN_W = 3 * S_W;

    localparam logic [CNT_W-1:0] SQ_N  = CNT_W'(31);
    localparam logic [CNT_W-1:0] ISQ_N = CNT_W'(32);
    localparam logic [CNT_W-1:0] MUL_N = CNT_W'(32);
    localparam logic [CNT_W-1:0] S_N   = CNT_W'(S_W);
    localparam logic [CNT_W-1:0] NUM_N = CNT_W'(NUM_W);

    localparam logic [W-1:0] ACC_MAX_W = (W'(1) << (ACC_WIDTH - 1)) - W'(1);
    localparam logic [W-1:0] ACC_MIN_W = ~ACC_MAX_W;
    localparam logic [W-1:0] S32_MAX_W = W'(32'h7FFF_FFFF);
    localparam logic [W-1:0] S32_MIN_W = ~S32_MAX_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQRT, S_SOFT, S_S2, S_S3, S_GM,
        S_NUMX, S_DIVX, S_ACCX, S_NUMY, S_DIVY, S_ACCY,
        S_DT2, S_DTAX, S_VX1, S_VX2, S_DTAY, S_VY1, S_VY2,
        S_OUT, S_CFGMUL, S_CFGSUB
    } state_t;

    function automatic logic [31:0] sat32_w(input logic [W-1:0] v);
        logic [31:0] r;
        if ($signed(v) > $signed(S32_MAX_W))
            r = 32'h7FFF_FFFF;
        else if ($signed(v) < $signed(S32_MIN_W))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [ACC_WIDTH-1:0] acc_sat(input logic [W-1:0] v);
        logic [ACC_WIDTH-1:0] r;
        if ($signed(v) > $signed(ACC_MAX_W))
            r = ACC_MAX_W[ACC_WIDTH-1:0];
        else if ($signed(v) < $signed(ACC_MIN_W))
            r = ACC_MIN_W[ACC_WIDTH-1:0];
        else
            r = v[ACC_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [W-1:0] sext32(input logic [31:0] v);
        return {{(W-32){v[31]}}, v};
    endfunction

    state_t               state_reg;
    logic [W-1:0]         p_reg, x_reg, n_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [31:0]          dxm_reg, dym_reg, mass_reg;
    logic                 dxneg_reg, dyneg_reg, half_reg, last_reg, axis_reg;
    logic [S_W-1:0]       s_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [63:0]          gm_reg;
    logic [40:0]          tmag_reg;
    logic                 tneg_reg;
    logic [31:0]          pos_x_reg, pos_y_reg, prev_x_reg, prev_y_reg;
    logic [ACC_WIDTH-1:0] acc_x_reg, acc_y_reg;

    logic [W-1:0] add_a, add_b, add_res;
    logic         add_sub, add_carry;

    logic [32:0]  dx_in, dy_in;
    logic [31:0]  dxm_in, dym_in, ax_in, ay_r;
    logic         half_in;
    logic [W-1:0] acc_w_x, acc_w_y, div_rs, sq_bit, q_w, q_mag, t_shift, t_cap;
    logic [31:0]  ax_sat, ay_sat, vsel, ssel;
    logic         is_mul, last_step;

    gvb_addsub u_addsub (
        .a     (add_a),
        .b     (add_b),
        .sub   (add_sub),
        .res   (add_res),
        .carry (add_carry)
    );

    always_comb
    begin
        dx_in   = {item.other_x[31], item.other_x} - {pos_x_reg[31], pos_x_reg};
        dy_in   = {item.other_y[31], item.other_y} - {pos_y_reg[31], pos_y_reg};
        dxm_in  = dx_in[32] ? 32'(~dx_in + 33'd1) : dx_in[31:0];
        dym_in  = dy_in[32] ? 32'(~dy_in + 33'd1) : dy_in[31:0];
        // large separations work on halved differences
        half_in = dxm_in[31] | dym_in[31];
        ax_in   = half_in ? (dxm_in >> 1) : dxm_in;
        ay_r    = half_reg ? (dym_reg >> 1) : dym_reg;

        acc_w_x = {{(W-ACC_WIDTH){acc_x_reg[ACC_WIDTH-1]}}, acc_x_reg};
        acc_w_y = {{(W-ACC_WIDTH){acc_y_reg[ACC_WIDTH-1]}}, acc_y_reg};
        ax_sat  = sat32_w(acc_w_x);
        ay_sat  = sat32_w(acc_w_y);

        div_rs  = {p_reg[W-2:0], n_reg[NUM_W-1]};
        sq_bit  = W'(1) << {cnt_reg - CNT_W'(1), 1'b0};
        q_w     = W'(n_reg[NUM_W-1:0]);
        q_mag   = (q_w > ACC_MAX_W) ? ACC_MAX_W : q_w;
        t_shift = add_res >> (2 * FRAC_BITS);
        t_cap   = (t_shift > gvb_pkg::DT2A_CAP) ? gvb_pkg::DT2A_CAP : t_shift;

        vsel    = reload.axis_y ? cfg.start_vy : cfg.start_vx;
        ssel    = axis_reg ? cfg.start_y : cfg.start_x;

        is_mul  = (state_reg == S_SQX) || (state_reg == S_SQY) || (state_reg == S_S2)
               || (state_reg == S_S3) || (state_reg == S_GM) || (state_reg == S_NUMX)
               || (state_reg == S_NUMY) || (state_reg == S_DT2) || (state_reg == S_DTAX)
               || (state_reg == S_DTAY) || (state_reg == S_CFGMUL);
        last_step = (cnt_reg == CNT_W'(1));
    end

    // operand selection for the shared unit
    always_comb
    begin
        add_a   = p_reg;
        add_b   = x_reg;
        add_sub = 1'b0;
        unique case (state_reg)
            S_SQX, S_SQY, S_S2, S_S3, S_GM, S_NUMX, S_NUMY,
            S_DT2, S_DTAX, S_DTAY, S_CFGMUL:
            begin
                add_b = n_reg[0] ? x_reg : '0;
            end
            S_SQRT:
            begin
                add_b   = x_reg | sq_bit;
                add_sub = 1'b1;
            end
            S_SOFT:
            begin
                add_a = half_reg ? W'({x_reg[31:0], 1'b0}) : W'(x_reg[31:0]);
                add_b = W'(cfg.softening);
            end
            S_DIVX, S_DIVY:
            begin
                add_a   = div_rs;
                add_sub = 1'b1;
            end
            S_ACCX:
            begin
                add_a   = acc_w_x;
                add_b   = q_mag;
                add_sub = dxneg_reg;
            end
            S_ACCY:
            begin
                add_a   = acc_w_y;
                add_b   = q_mag;
                add_sub = dyneg_reg;
            end
            S_VX1:
            begin
                add_a   = sext32(pos_x_reg) << 1;
                add_b   = sext32(prev_x_reg);
                add_sub = 1'b1;
            end
            S_VY1:
            begin
                add_a   = sext32(pos_y_reg) << 1;
                add_b   = sext32(prev_y_reg);
                add_sub = 1'b1;
            end
            S_VX2, S_VY2:
            begin
                add_b   = W'(tmag_reg);
                add_sub = tneg_reg;
            end
            S_CFGSUB:
            begin
                add_a   = sext32(ssel);
                add_b   = p_reg >> FRAC_BITS;
                add_sub = ~(axis_reg ? cfg.start_vy[31] : cfg.start_vx[31]);
            end
            default:
            begin
                add_b = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            acc_x_reg  <= '0;
            acc_y_reg  <= '0;
        end
        else
        begin
            // shift-add step shared by every multiply; the last step is taken per state
            if (is_mul && !last_step)
            begin
                p_reg   <= add_res;
                x_reg   <= x_reg << 1;
                n_reg   <= n_reg >> 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (reload.valid)
                    begin
                        axis_reg  <= reload.axis_y;
                        p_reg     <= '0;
                        x_reg     <= W'(cfg.time_step);
                        n_reg     <= W'(mag32(vsel));
                        cnt_reg   <= MUL_N;
                        state_reg <= S_CFGMUL;
                    end
                    else if (start)
                    begin
                        dxm_reg   <= dxm_in;
                        dym_reg   <= dym_in;
                        dxneg_reg <= dx_in[32];
                        dyneg_reg <= dy_in[32];
                        half_reg  <= half_in;
                        mass_reg  <= item.other_mass;
                        last_reg  <= item.last;
                        p_reg     <= '0;
                        x_reg     <= W'(ax_in);
                        n_reg     <= W'(ax_in);
                        cnt_reg   <= SQ_N;
                        state_reg <= S_SQX;
                    end
                end
                S_SQX:
                begin
                    if (last_step)
                    begin
                        // ay^2 accumulates on top of ax^2
                        p_reg     <= add_res;
                        x_reg     <= W'(ay_r);
                        n_reg     <= W'(ay_r);
                        cnt_reg   <= SQ_N;
                        state_reg <= S_SQY;
                    end
                end
                S_SQY:
                begin
                    if (last_step)
                    begin
                        p_reg     <= add_res;
                        x_reg     <= '0;
                        cnt_reg   <= ISQ_N;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (add_carry)
                    begin
                        p_reg <= add_res;
                        x_reg <= (x_reg >> 1) | sq_bit;
                    end
                    else
                    begin
                        x_reg <= x_reg >> 1;
                    end
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (last_step)
                        state_reg <= S_SOFT;
                end
                S_SOFT:
                begin
                    s_reg <= add_res[S_W-1:0];
                    if (add_res == '0)
                    begin
                        // a zero softened distance contributes nothing
                        if (last_reg)
                        begin
                            p_reg     <= '0;
                            x_reg     <= W'(cfg.time_step);
                            n_reg     <= W'(cfg.time_step);
                            cnt_reg   <= MUL_N;
                            state_reg <= S_DT2;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        p_reg     <= '0;
                        x_reg     <= W'(add_res[S_W-1:0]);
                        n_reg     <= W'(add_res[S_W-1:0]);
                        cnt_reg   <= S_N;
                        state_reg <= S_S2;
                    end
                end
                S_S2:
                begin
                    if (last_step)
                    begin
                        p_reg     <= '0;
                        x_reg     <= add_res;
                        n_reg     <= W'(s_reg);
                        cnt_reg   <= S_N;
                        state_reg <= S_S3;
                    end
                end
                S_S3:
                begin
                    if (last_step)
                    begin
                        den_reg   <= add_res[DEN_W-1:0];
                        p_reg     <= '0;
                        x_reg     <= W'(cfg.grav_const);
                        n_reg     <= W'(mass_reg);
                        cnt_reg   <= MUL_N;
                        state_reg <= S_GM;
                    end
                end
                S_GM:
                begin
                    if (last_step)
                    begin
                        gm_reg    <= add_res[63:0];
                        p_reg     <= '0;
                        x_reg     <= add_res;
                        n_reg     <= W'(dxm_reg);
                        cnt_reg   <= MUL_N;
                        state_reg <= S_NUMX;
                    end
                end
                S_NUMX, S_NUMY:
                begin
                    if (last_step)
                    begin
                        p_reg     <= '0;
                        x_reg     <= W'(den_reg);
                        n_reg     <= add_res << FRAC_BITS;
                        cnt_reg   <= NUM_N;
                        state_reg <= (state_reg == S_NUMX) ? S_DIVX : S_DIVY;
                    end
                end
                S_DIVX, S_DIVY:
                begin
                    p_reg   <= add_carry ? add_res : div_rs;
                    n_reg   <= {n_reg[W-2:0], add_carry};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (last_step)
                        state_reg <= (state_reg == S_DIVX) ? S_ACCX : S_ACCY;
                end
                S_ACCX:
                begin
                    acc_x_reg <= acc_sat(add_res);
                    p_reg     <= '0;
                    x_reg     <= W'(gm_reg);
                    n_reg     <= W'(dym_reg);
                    cnt_reg   <= MUL_N;
                    state_reg <= S_NUMY;
                end
                S_ACCY:
                begin
                    acc_y_reg <= acc_sat(add_res);
                    if (last_reg)
                    begin
                        p_reg     <= '0;
                        x_reg     <= W'(cfg.time_step);
                        n_reg     <= W'(cfg.time_step);
                        cnt_reg   <= MUL_N;
                        state_reg <= S_DT2;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DT2:
                begin
                    if (last_step)
                    begin
                        gm_reg    <= add_res[63:0];
                        p_reg     <= '0;
                        x_reg     <= add_res;
                        n_reg     <= W'(mag32(ax_sat));
                        cnt_reg   <= MUL_N;
                        state_reg <= S_DTAX;
                    end
                end
                S_DTAX, S_DTAY:
                begin
                    if (last_step)
                    begin
                        tmag_reg  <= t_cap[40:0];
                        tneg_reg  <= (state_reg == S_DTAX) ? ax_sat[31] : ay_sat[31];
                        state_reg <= (state_reg == S_DTAX) ? S_VX1 : S_VY1;
                    end
                end
                S_VX1:
                begin
                    p_reg     <= add_res;
                    state_reg <= S_VX2;
                end
                S_VX2:
                begin
                    prev_x_reg <= pos_x_reg;
                    pos_x_reg  <= sat32_w(add_res);
                    p_reg      <= '0;
                    x_reg      <= W'(gm_reg);
                    n_reg      <= W'(mag32(ay_sat));
                    cnt_reg    <= MUL_N;
                    state_reg  <= S_DTAY;
                end
                S_VY1:
                begin
                    p_reg     <= add_res;
                    state_reg <= S_VY2;
                end
                S_VY2:
                begin
                    prev_y_reg <= pos_y_reg;
                    pos_y_reg  <= sat32_w(add_res);
                    state_reg  <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        acc_x_reg <= '0;
                        acc_y_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_CFGMUL:
                begin
                    if (last_step)
                    begin
                        p_reg     <= add_res;
                        state_reg <= S_CFGSUB;
                    end
                end
                S_CFGSUB:
                begin
                    if (axis_reg)
                    begin
                        pos_y_reg  <= cfg.start_y;
                        prev_y_reg <= sat32_w(add_res);
                    end
                    else
                    begin
                        pos_x_reg  <= cfg.start_x;
                        prev_x_reg <= sat32_w(add_res);
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        idle          = (state_reg == S_IDLE);
        res_valid     = (state_reg == S_OUT);
        res.new_x     = pos_x_reg;
        res.new_y     = pos_y_reg;
        res.accel_x   = ax_sat;
        res.accel_y   = ay_sat;
    end

endmodule

`default_nettype wire

### sv/gravity_verlet_body_step.sv
// One 2D body under softened gravity, Q16.16 by default. Each input word is another body's
// position and mass; its pull G*m*d/(|d|+eps)^3 is added to an acceleration sum, and on the
// word marked tlast the body takes a position-Verlet step and one output word carries the new
// position and the saturated acceleration. All arithmetic past the input differences runs
// bit-serially through one shared 128-bit add/subtract unit: per item two squares, a square
// root, five multiplies and two divisions with 96+FRAC_BITS quotient bits (112 at Q16.16); a
// last item adds the update, and a body at zero softened distance skips the force terms. A
// write of a start position or velocity recomputes that axis's state. s_tready and cfg_ready
// are low while the unit is busy; a finished word waits in the output register without
// stalling the next item.
`default_nettype none

module gravity_verlet_body_step #(
    parameter int FRAC_BITS = gvb_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = gvb_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [gvb_pkg::IN_W-1:0]        s_tdata,   // other_x, other_y, other_mass
    input  wire logic                            s_tlast,   // last
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [gvb_pkg::OUT_W-1:0]       m_tdata,   // new_x, new_y, accel_x, accel_y
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gvb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]                     cfg_data
);

    gvb_pkg::cfg_t    cfg_reg;
    gvb_pkg::reload_t reload_reg;
    gvb_pkg::item_t   item;
    gvb_pkg::res_t    res;
    logic             core_idle, res_valid, res_ready, start, cfg_wr;
    logic             m_tvalid_reg;
    logic [gvb_pkg::OUT_W-1:0] m_tdata_reg;

    always_comb
    begin
        cfg_ready       = core_idle & ~reload_reg.valid;
        s_tready        = cfg_ready & ~cfg_valid;
        start           = s_tvalid & s_tready;
        cfg_wr          = cfg_valid & cfg_ready;
        item.other_x    = s_tdata[31:0];
        item.other_y    = s_tdata[63:32];
        item.other_mass = s_tdata[95:64];
        item.last       = s_tlast;
        res_ready       = ~m_tvalid_reg | m_tready;
        m_tvalid        = m_tvalid_reg;
        m_tdata         = m_tdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x    <= '0;
            cfg_reg.start_y    <= '0;
            cfg_reg.start_vx   <= '0;
            cfg_reg.start_vy   <= '0;
            cfg_reg.time_step  <= 32'(1) << FRAC_BITS;
            cfg_reg.grav_const <= 32'(1) << FRAC_BITS;
            cfg_reg.softening  <= 32'(1) << FRAC_BITS;
            reload_reg         <= '0;
        end
        else
        begin
            // start position or velocity reloads that axis
            reload_reg.valid <= cfg_wr
                && (cfg_index == gvb_pkg::CFG_START_X || cfg_index == gvb_pkg::CFG_START_VX
                    || cfg_index == gvb_pkg::CFG_START_Y
                    || cfg_index == gvb_pkg::CFG_START_VY);
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    gvb_pkg::CFG_START_X:    cfg_reg.start_x    <= cfg_data;
                    gvb_pkg::CFG_START_Y:    cfg_reg.start_y    <= cfg_data;
                    gvb_pkg::CFG_START_VX:   cfg_reg.start_vx   <= cfg_data;
                    gvb_pkg::CFG_START_VY:   cfg_reg.start_vy   <= cfg_data;
                    gvb_pkg::CFG_TIME_STEP:  cfg_reg.time_step  <= cfg_data;
                    gvb_pkg::CFG_GRAV_CONST: cfg_reg.grav_const <= cfg_data;
                    gvb_pkg::CFG_SOFTENING:  cfg_reg.softening  <= cfg_data;
                    default:                 cfg_reg.softening  <= cfg_reg.softening;
                endcase
                if (cfg_index == gvb_pkg::CFG_START_X || cfg_index == gvb_pkg::CFG_START_VX)
                begin
                    reload_reg.axis_y <= 1'b0;
                end
                else if (cfg_index == gvb_pkg::CFG_START_Y
                         || cfg_index == gvb_pkg::CFG_START_VY)
                begin
                    reload_reg.axis_y <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {res.accel_y, res.accel_x, res.new_y, res.new_x};
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    gvb_core #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .reload    (reload_reg),
        .start     (start),
        .item      (item),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

### sv/gvb_checker.sv
`default_nettype none
`include "gravity_verlet_body_step_macros.svh"

module gvb_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic [gvb_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [gvb_pkg::OUT_W-1:0]     m_tdata
);

    // an item and a register write never land on the same edge
    `GVB_ASSERT_NOW(a_no_mix, clk, rst_n, s_tvalid && s_tready, !(cfg_valid && cfg_ready))

    // the unit is busy right after it takes an item
    `GVB_ASSERT_NEXT(a_busy_item, clk, rst_n, s_tvalid && s_tready, !s_tready && !cfg_ready)

    // a start register write recomputes state before anything else goes in
    `GVB_ASSERT_NEXT(a_busy_reload, clk, rst_n,
        cfg_valid && cfg_ready && (cfg_index == gvb_pkg::CFG_START_X
            || cfg_index == gvb_pkg::CFG_START_Y || cfg_index == gvb_pkg::CFG_START_VX
            || cfg_index == gvb_pkg::CFG_START_VY),
        !s_tready && !cfg_ready)

    `GVB_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

endmodule

bind gravity_verlet_body_step gvb_checker u_gvb_checker (.*);

`default_nettype wire
